// ===== hw/rtl/mrt_pkg.sv =====
// Shared types, codes and sizes for the modulation route table.
package mrt_pkg;

  localparam int DEF_MAX_ROUTES = 32;
  localparam int DEF_NUM_SLOTS  = 16;

  localparam int FUNC_W   = 3;
  localparam int SLOT_W   = 4;
  localparam int DEST_W   = 8;
  localparam int RANGE_W  = 16;
  localparam int LEVEL_W  = 16;
  localparam int STATUS_W = 2;
  localparam int SUM_W    = 40;
  localparam int COUNT_W  = 6;
  localparam int PROD_W   = LEVEL_W + RANGE_W + 1;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 48;

  localparam logic [FUNC_W-1:0] FN_QUERY  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_ADD    = 3'd1;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd2;
  localparam logic [FUNC_W-1:0] FN_PURGE  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_WRITE  = 3'd4;

  localparam logic [STATUS_W-1:0] STS_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] STS_SAME = 2'd1;
  localparam logic [STATUS_W-1:0] STS_FULL = 2'd2;
  localparam logic [STATUS_W-1:0] STS_DUP  = 2'd3;

  typedef struct packed {
    logic [DEST_W-1:0] dest;
    logic [SLOT_W-1:0] target;
    logic [SLOT_W-1:0] source;
  } route_t;

  typedef struct packed {
    logic clr;
    logic en;
  } mac_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

endpackage

// ===== hw/rtl/mrt_route_mem.sv =====
// Route entry memory: one write port, one registered read port.
module mrt_route_mem
  import mrt_pkg::*;
#(
  parameter int MAX_ROUTES = DEF_MAX_ROUTES,
  localparam int RIDX_W = $clog2(MAX_ROUTES)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [RIDX_W-1:0] waddr,
  input  route_t            wdata,
  input  logic              re,
  input  logic [RIDX_W-1:0] raddr,
  output route_t            rdata
);

  route_t mem [MAX_ROUTES];
  route_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/mrt_level_mem.sv =====
// Source level memory with per-slot valid bits and registered read.
module mrt_level_mem
  import mrt_pkg::*;
#(
  parameter int NUM_SLOTS = DEF_NUM_SLOTS,
  localparam int SIDX_W = $clog2(NUM_SLOTS)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      we,
  input  logic [SLOT_W-1:0]         wslot,
  input  logic signed [LEVEL_W-1:0] wdata,
  input  logic                      re,
  input  logic [SLOT_W-1:0]         rslot,
  output logic signed [LEVEL_W-1:0] rdata
);

  logic signed [LEVEL_W-1:0] mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]      vld_r;
  logic signed [LEVEL_W-1:0] lvl_r;
  logic                      hit_r;
  logic [31:0]               wext;
  logic [31:0]               rext;
  logic                      w_in;
  logic                      r_in;
  logic [SIDX_W-1:0]         widx;
  logic [SIDX_W-1:0]         ridx;

  assign wext = 32'(wslot);
  assign rext = 32'(rslot);
  assign w_in = wext < 32'(NUM_SLOTS);
  assign r_in = rext < 32'(NUM_SLOTS);
  assign widx = wext[SIDX_W-1:0];
  assign ridx = rext[SIDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we && w_in) begin
      vld_r[widx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we && w_in) begin
      mem[widx] <= wdata;
    end
    if (re) begin
      lvl_r <= mem[ridx];
      hit_r <= r_in && vld_r[ridx];
    end
  end

  assign rdata = hit_r ? lvl_r : '0;

endmodule

// ===== hw/rtl/mrt_mac.sv =====
// Multiply-accumulate unit: level times range, summed over a scan.
module mrt_mac
  import mrt_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  mac_ctl_t                  ctl,
  input  logic signed [LEVEL_W-1:0] level,
  input  logic [RANGE_W-1:0]        rng,
  output logic                      busy,
  output logic signed [SUM_W-1:0]   sum
);

  logic signed [PROD_W-1:0] a_ext;
  logic signed [PROD_W-1:0] b_ext;
  logic signed [PROD_W-1:0] prod_r;
  logic                     pv_r;
  logic signed [SUM_W-1:0]  acc_r;

  assign a_ext = {{(RANGE_W + 1){level[LEVEL_W-1]}}, level};
  assign b_ext = {{(LEVEL_W + 1){1'b0}}, rng};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= ctl.en;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      prod_r <= a_ext * b_ext;
    end
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (pv_r) begin
      acc_r <= acc_r + {{(SUM_W - PROD_W){prod_r[PROD_W-1]}}, prod_r};
    end
  end

  assign busy = pv_r;
  assign sum  = acc_r;

endmodule

// ===== hw/rtl/modulation_route_table_top.sv =====
// Top level of the modulation route table: sequencer, handshakes and result register.
//
//   channel  direction  ports                         payload
//   in_      slave      in_tvalid/in_tready/in_tdata   func, slots, dest, range, level
//   out_     master     out_tvalid/out_tready/out_tdata status, offset_sum, route_count
//
// A level write, an unused code or an add refused for equal slots or a full table
// goes straight from acceptance to the finishing step. Query, add, remove and purge
// scan the held routes one per cycle through the single route memory read port, then
// drain the entry read, level read and multiply-accumulate registers before finishing.
// Reset clears the route count and every level valid bit at once; no clearing pass.
// in_tready stays low from acceptance until the result is loaded; a stalled result
// holds the sequencer in its finishing step.
module modulation_route_table_top
  import mrt_pkg::*;
#(
  parameter int MAX_ROUTES = DEF_MAX_ROUTES,
  parameter int NUM_SLOTS  = DEF_NUM_SLOTS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // func[2:0], source_slot[6:3], target_slot[10:7], dest_param[18:11],
  // range_scale[34:19], lfo_sample[50:35], zero fill [55:51]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // status[1:0], offset_sum[41:2], route_count[47:42]
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int RIDX_W = $clog2(MAX_ROUTES);
  localparam int CNT_W  = $clog2(MAX_ROUTES + 1);

  logic [FUNC_W-1:0]         in_func;
  logic [SLOT_W-1:0]         in_src;
  logic [SLOT_W-1:0]         in_tgt;
  logic [DEST_W-1:0]         in_dst;
  logic [RANGE_W-1:0]        in_rng;
  logic signed [LEVEL_W-1:0] in_lvl;

  assign in_func = in_tdata[2:0];
  assign in_src  = in_tdata[6:3];
  assign in_tgt  = in_tdata[10:7];
  assign in_dst  = in_tdata[18:11];
  assign in_rng  = in_tdata[34:19];
  assign in_lvl  = in_tdata[50:35];

  state_t                state_r, state_nxt;
  logic [FUNC_W-1:0]     func_r;
  logic [SLOT_W-1:0]     src_r;
  logic [SLOT_W-1:0]     tgt_r;
  logic [DEST_W-1:0]     dst_r;
  logic [RANGE_W-1:0]    rng_r;
  logic [CNT_W-1:0]      held_r, held_nxt;
  logic [CNT_W-1:0]      i_r, i_nxt;
  logic [CNT_W-1:0]      w_r, w_nxt;
  logic                  va_r, va_nxt;
  logic                  lb_r, lb_nxt;
  logic                  removed_r, removed_nxt;
  logic [STATUS_W-1:0]   status_r, status_nxt;
  logic                  out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  logic                      accept;
  logic                      out_free;
  logic                      rm_we;
  logic [RIDX_W-1:0]         rm_waddr;
  route_t                    rm_wdata;
  logic                      rm_re;
  route_t                    entry;
  logic                      lv_re;
  logic signed [LEVEL_W-1:0] lv_rdata;
  mac_ctl_t                  mac_ctl;
  logic                      mac_busy;
  logic signed [SUM_W-1:0]   mac_sum;
  logic                      keep;
  logic                      finish;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign finish    = (state_r == S_FINISH) && out_free;

  mrt_route_mem #(
    .MAX_ROUTES(MAX_ROUTES)
  ) u_route_mem (
    .clk  (clk),
    .we   (rm_we),
    .waddr(rm_waddr),
    .wdata(rm_wdata),
    .re   (rm_re),
    .raddr(i_r[RIDX_W-1:0]),
    .rdata(entry)
  );

  mrt_level_mem #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_level_mem (
    .clk  (clk),
    .rst_n(rst_n),
    .we   (accept && (in_func == FN_WRITE)),
    .wslot(in_src),
    .wdata(in_lvl),
    .re   (lv_re),
    .rslot(entry.source),
    .rdata(lv_rdata)
  );

  mrt_mac u_mac (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (mac_ctl),
    .level(lv_rdata),
    .rng  (rng_r),
    .busy (mac_busy),
    .sum  (mac_sum)
  );

  always_comb begin
    state_nxt   = state_r;
    held_nxt    = held_r;
    i_nxt       = i_r;
    w_nxt       = w_r;
    va_nxt      = 1'b0;
    removed_nxt = removed_r;
    status_nxt  = status_r;
    rm_re       = 1'b0;
    rm_we       = 1'b0;
    rm_waddr    = w_r[RIDX_W-1:0];
    rm_wdata    = entry;
    lv_re       = 1'b0;
    keep        = 1'b1;
    mac_ctl.clr = accept;
    mac_ctl.en  = lb_r;

    // evaluate the entry read in the previous cycle
    if (va_r) begin
      case (func_r)
        FN_REMOVE: begin
          if (!removed_r && entry.source == src_r && entry.target == tgt_r &&
              entry.dest == dst_r) begin
            keep        = 1'b0;
            removed_nxt = 1'b1;
          end
        end
        FN_PURGE: begin
          if (entry.source == src_r || entry.target == src_r) begin
            keep = 1'b0;
          end
        end
        FN_ADD: begin
          if (entry.source == src_r && entry.dest == dst_r) begin
            status_nxt = STS_DUP;
          end
        end
        FN_QUERY: begin
          lv_re = (entry.dest == dst_r);
        end
        default: begin
        end
      endcase
      if (keep && (func_r == FN_REMOVE || func_r == FN_PURGE)) begin
        rm_we = 1'b1;
        w_nxt = w_r + CNT_W'(1);
      end
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          i_nxt       = '0;
          w_nxt       = '0;
          removed_nxt = 1'b0;
          status_nxt  = STS_DONE;
          case (in_func)
            FN_QUERY, FN_REMOVE, FN_PURGE: begin
              state_nxt = S_SCAN;
            end
            FN_ADD: begin
              if (in_src == in_tgt) begin
                status_nxt = STS_SAME;
                state_nxt  = S_FINISH;
              end else if (held_r == CNT_W'(MAX_ROUTES)) begin
                status_nxt = STS_FULL;
                state_nxt  = S_FINISH;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
              state_nxt = S_FINISH;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (i_r < held_r) begin
          rm_re  = 1'b1;
          va_nxt = 1'b1;
          i_nxt  = i_r + CNT_W'(1);
        end else begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!va_r && !lb_r && !mac_busy) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_nxt = S_IDLE;
          if (func_r == FN_REMOVE || func_r == FN_PURGE) begin
            held_nxt = w_r;
          end else if (func_r == FN_ADD && status_r == STS_DONE) begin
            rm_we    = 1'b1;
            rm_waddr = held_r[RIDX_W-1:0];
            rm_wdata = '{dest: dst_r, target: tgt_r, source: src_r};
            held_nxt = held_r + CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign lb_nxt = lv_re;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      held_r       <= '0;
      va_r         <= 1'b0;
      lb_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
      va_r    <= va_nxt;
      lb_r    <= lb_nxt;
      if (finish) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r       <= i_nxt;
    w_r       <= w_nxt;
    removed_r <= removed_nxt;
    status_r  <= status_nxt;
    if (accept) begin
      func_r <= in_func;
      src_r  <= in_src;
      tgt_r  <= in_tgt;
      dst_r  <= in_dst;
      rng_r  <= in_rng;
    end
    if (finish) begin
      out_tdata_r <= {COUNT_W'(held_nxt), mac_sum, status_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef ASSERT_OFF
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CNT_W'(MAX_ROUTES))
    else $error("route count beyond table size");

  a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_DRAIN) |-> (w_r <= i_r))
    else $error("compaction write pointer passed read pointer");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_FINISH))
    else $error("result raised outside finishing step");

  a_held_step: assert property (@(posedge clk) disable iff (!rst_n)
    (finish && func_r != FN_PURGE) |=>
      (held_r == $past(held_r) || held_r == $past(held_r) + CNT_W'(1) ||
       held_r == $past(held_r) - CNT_W'(1)))
    else $error("route count moved by more than one");
`endif

endmodule

// ===== test/modulation_route_table_top_tb.sv =====
// Self-checking testbench for the route table: directed, fill, stall and random traffic.
module modulation_route_table_top_tb
  import mrt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [FUNC_W-1:0] FN_SPARE_FIRST = 3'd5;
  localparam int CYCLE_LIMIT  = 800000;
  localparam int DRAIN_CYCLES = 60;
  localparam int STALL_CYCLES = 400;

  typedef struct {
    logic [FUNC_W-1:0]         func;
    logic [SLOT_W-1:0]         src;
    logic [SLOT_W-1:0]         tgt;
    logic [DEST_W-1:0]         dst;
    logic [RANGE_W-1:0]        rng;
    logic signed [LEVEL_W-1:0] lvl;
  } route_op_t;

  typedef struct {
    logic [STATUS_W-1:0]     status;
    logic signed [SUM_W-1:0] offset;
    logic [COUNT_W-1:0]      count;
  } route_result_t;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // func[2:0], source_slot[6:3], target_slot[10:7], dest_param[18:11],
  // range_scale[34:19], lfo_sample[50:35], zero fill [55:51]
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // status[1:0], offset_sum[41:2], route_count[47:42]
  logic [OUT_TDATA_W-1:0] out_tdata;

  logic [SLOT_W-1:0]         tbl_src [DEF_MAX_ROUTES];
  logic [SLOT_W-1:0]         tbl_tgt [DEF_MAX_ROUTES];
  logic [DEST_W-1:0]         tbl_dst [DEF_MAX_ROUTES];
  logic signed [LEVEL_W-1:0] slot_level [DEF_NUM_SLOTS];
  int unsigned               held = 0;
  route_result_t             pending_results[$];

  int errors = 0;
  int checked = 0;
  int cycles = 0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int hold_request = 0;
  int op_seen [8] = '{default: 0};
  int refused_adds = 0;
  int peak_held = 0;

  modulation_route_table_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic route_result_t apply_route_op(route_op_t op);
    route_result_t r;
    longint        acc;
    int unsigned   w;
    bit            hit;
    r.status = STS_DONE;
    acc = 0;
    hit = 1'b0;
    w = 0;
    case (op.func)
      FN_QUERY: begin
        for (int i = 0; i < held; i++)
          if (tbl_dst[i] == op.dst && tbl_src[i] < DEF_NUM_SLOTS)
            acc += longint'(slot_level[tbl_src[i]]) * longint'(op.rng);
      end
      FN_ADD: begin
        if (op.src == op.tgt) begin
          r.status = STS_SAME;
        end else if (held >= DEF_MAX_ROUTES) begin
          r.status = STS_FULL;
        end else begin
          for (int i = 0; i < held; i++)
            if (tbl_src[i] == op.src && tbl_dst[i] == op.dst) hit = 1'b1;
          if (hit) begin
            r.status = STS_DUP;
          end else begin
            tbl_src[held] = op.src;
            tbl_tgt[held] = op.tgt;
            tbl_dst[held] = op.dst;
            held++;
          end
        end
      end
      FN_REMOVE: begin
        for (int i = 0; i < held; i++) begin
          if (!hit && tbl_src[i] == op.src && tbl_tgt[i] == op.tgt &&
              tbl_dst[i] == op.dst) begin
            hit = 1'b1;
            for (int j = i; j + 1 < held; j++) begin
              tbl_src[j] = tbl_src[j+1];
              tbl_tgt[j] = tbl_tgt[j+1];
              tbl_dst[j] = tbl_dst[j+1];
            end
            held--;
          end
        end
      end
      FN_PURGE: begin
        for (int i = 0; i < held; i++) begin
          if (tbl_src[i] != op.src && tbl_tgt[i] != op.src) begin
            tbl_src[w] = tbl_src[i];
            tbl_tgt[w] = tbl_tgt[i];
            tbl_dst[w] = tbl_dst[i];
            w++;
          end
        end
        held = w;
      end
      FN_WRITE: begin
        if (op.src < DEF_NUM_SLOTS) slot_level[op.src] = op.lvl;
      end
      default: ;
    endcase
    r.offset = acc[SUM_W-1:0];
    r.count  = held[COUNT_W-1:0];
    return r;
  endfunction

  function automatic route_op_t mk_op(logic [FUNC_W-1:0] func, logic [SLOT_W-1:0] src,
                                      logic [SLOT_W-1:0] tgt, logic [DEST_W-1:0] dst,
                                      logic [RANGE_W-1:0] rng, logic [LEVEL_W-1:0] lvl);
    route_op_t op;
    op.func = func;
    op.src  = src;
    op.tgt  = tgt;
    op.dst  = dst;
    op.rng  = rng;
    op.lvl  = lvl;
    return op;
  endfunction

  function automatic route_op_t rand_route_op(int add_pct);
    route_op_t op;
    int        k;
    int        pick;
    op.func = FN_QUERY;
    op.src  = SLOT_W'($urandom_range(15));
    op.tgt  = SLOT_W'($urandom_range(15));
    op.dst  = ($urandom_range(3) == 0) ? DEST_W'($urandom_range(255)) :
                                         DEST_W'($urandom_range(7));
    op.rng  = RANGE_W'($urandom_range(65535));
    op.lvl  = LEVEL_W'($urandom_range(65535));
    pick    = (held > 0) ? $urandom_range(held - 1) : 0;
    k       = $urandom_range(99);
    if (k < 16) begin
      op.func = FN_WRITE;
    end else if (k < 16 + add_pct) begin
      op.func = FN_ADD;
    end else if (k < 31 + add_pct) begin
      op.func = FN_REMOVE;
      if (held > 0 && $urandom_range(4) != 0) begin
        op.src = tbl_src[pick];
        op.tgt = tbl_tgt[pick];
        op.dst = tbl_dst[pick];
      end
    end else if (k < 35 + add_pct) begin
      op.func = FN_PURGE;
      if (held > 0 && $urandom_range(1) == 0)
        op.src = $urandom_range(1) ? tbl_src[pick] : tbl_tgt[pick];
    end else if (k < 38 + add_pct) begin
      op.func = FN_SPARE_FIRST + FUNC_W'($urandom_range(2));
    end else begin
      if (held > 0 && $urandom_range(1) == 0) op.dst = tbl_dst[pick];
      case ($urandom_range(7))
        0: op.rng = '0;
        1: op.rng = '1;
        default: ;
      endcase
    end
    return op;
  endfunction

  task automatic send_route_op(route_op_t op);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W-51){1'b0}}, op.lvl, op.rng, op.dst, op.tgt, op.src, op.func};
    do @(posedge clk); while (in_tready !== 1'b1);
    pending_results.push_back(apply_route_op(op));
    op_seen[op.func]++;
    if (op.func == FN_ADD && pending_results[$].status != STS_DONE) refused_adds++;
    if (held > peak_held) peak_held = held;
  endtask

  task automatic test_level_writes();
    send_route_op(mk_op(FN_WRITE, 4'd0, 4'd0, 8'd0, 16'd0, 16'h8000));
    send_route_op(mk_op(FN_WRITE, 4'd15, 4'd0, 8'd0, 16'd0, 16'h7FFF));
    send_route_op(mk_op(FN_WRITE, 4'd3, 4'd0, 8'd0, 16'd0, 16'hFFFF));
    send_route_op(mk_op(FN_WRITE, 4'd4, 4'd0, 8'd0, 16'd0, LEVEL_W'($urandom_range(65535))));
  endtask

  task automatic test_route_edits();
    send_route_op(mk_op(FN_ADD, 4'd7, 4'd7, 8'd1, 16'd0, 16'd0));
    send_route_op(mk_op(FN_ADD, 4'd0, 4'd1, 8'd10, 16'd0, 16'd0));
    send_route_op(mk_op(FN_ADD, 4'd15, 4'd2, 8'd10, 16'd0, 16'd0));
    send_route_op(mk_op(FN_ADD, 4'd0, 4'd3, 8'd10, 16'd0, 16'd0));
    send_route_op(mk_op(FN_ADD, 4'd0, 4'd3, 8'd255, 16'd0, 16'd0));
    send_route_op(mk_op(FN_ADD, 4'd4, 4'd15, 8'd20, 16'd0, 16'd0));
    send_route_op(mk_op(FN_QUERY, 4'd0, 4'd0, 8'd10, 16'hFFFF, 16'd0));
    send_route_op(mk_op(FN_QUERY, 4'd0, 4'd0, 8'd10, 16'h0000, 16'd0));
    send_route_op(mk_op(FN_QUERY, 4'd0, 4'd0, 8'd255, 16'h0100, 16'd0));
    send_route_op(mk_op(FN_QUERY, 4'd0, 4'd0, 8'd99, 16'h1234, 16'd0));
    send_route_op(mk_op(FN_REMOVE, 4'd15, 4'd2, 8'd10, 16'd0, 16'd0));
    send_route_op(mk_op(FN_REMOVE, 4'd15, 4'd2, 8'd10, 16'd0, 16'd0));
    for (int f = FN_SPARE_FIRST; f < 8; f++)
      send_route_op(mk_op(FUNC_W'(f), 4'd9, 4'd5, 8'd10, 16'hFFFF, 16'h7FFF));
    send_route_op(mk_op(FN_PURGE, 4'd15, 4'd0, 8'd0, 16'd0, 16'd0));
    send_route_op(mk_op(FN_PURGE, 4'd0, 4'd0, 8'd0, 16'd0, 16'd0));
    send_route_op(mk_op(FN_QUERY, 4'd0, 4'd0, 8'd10, 16'hFFFF, 16'd0));
  endtask

  task automatic test_table_full();
    route_op_t op;
    int        tries;
    tries = 0;
    repeat (4) send_route_op(mk_op(FN_WRITE, SLOT_W'($urandom_range(15)), 4'd0, 8'd0, 16'd0,
                                   LEVEL_W'($urandom_range(65535))));
    while (held < DEF_MAX_ROUTES && tries < 400) begin
      op = rand_route_op(0);
      op.func = FN_ADD;
      op.tgt  = op.src + 4'd1 + 4'($urandom_range(14));
      op.dst  = DEST_W'($urandom_range(255));
      send_route_op(op);
      tries++;
    end
    send_route_op(mk_op(FN_ADD, 4'd1, 4'd2, 8'd200, 16'd0, 16'd0));
    send_route_op(mk_op(FN_ADD, 4'd6, 4'd6, 8'd200, 16'd0, 16'd0));
    send_route_op(mk_op(FN_QUERY, 4'd0, 4'd0, tbl_dst[0], 16'hFFFF, 16'd0));
    send_route_op(mk_op(FN_REMOVE, tbl_src[held-1], tbl_tgt[held-1], tbl_dst[held-1],
                        16'd0, 16'd0));
    send_route_op(mk_op(FN_ADD, 4'd1, 4'd2, 8'd200, 16'd0, 16'd0));
    send_route_op(mk_op(FN_PURGE, tbl_src[5], 4'd0, 8'd0, 16'd0, 16'd0));
  endtask

  task automatic test_backpressure();
    hold_request = STALL_CYCLES;
    repeat (12) send_route_op(rand_route_op(30));
  endtask

  task automatic test_random(int count, int add_pct);
    repeat (count) send_route_op(rand_route_op(add_pct));
  endtask

  initial begin
    route_result_t want;
    int            stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid === 1'b1 && out_tready) begin
        checked++;
        if (pending_results.size() == 0) begin
          $error("result with no transaction outstanding: tdata %h", out_tdata);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_tdata[1:0] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_tdata[1:0]);
            errors++;
          end
          if (out_tdata[41:2] !== want.offset) begin
            $error("offset_sum: expected %0d, got %0d", want.offset, $signed(out_tdata[41:2]));
            errors++;
          end
          if (out_tdata[47:42] !== want.count) begin
            $error("route_count: expected %0d, got %0d", want.count, out_tdata[47:42]);
            errors++;
          end
        end
      end
      if (hold_request > 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles, %0d results outstanding", cycles,
             pending_results.size());
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    foreach (slot_level[s]) slot_level[s] = '0;
    src_idle_pct = 19;
    snk_idle_pct = 46;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_level_writes();
    test_route_edits();
    test_table_full();
    test_random(500, 30);

    src_idle_pct = 46;
    snk_idle_pct = 19;
    test_random(500, 45);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_backpressure();
    test_random(500, 25);

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display(
      "Ran %0d queries, %0d adds (%0d refused), %0d removes, %0d purges, %0d writes, %0d spare",
      op_seen[FN_QUERY], op_seen[FN_ADD], refused_adds, op_seen[FN_REMOVE],
      op_seen[FN_PURGE], op_seen[FN_WRITE], op_seen[5] + op_seen[6] + op_seen[7]);
    $display("Checked %0d results with %0d mismatches; route table peaked at %0d entries",
             checked, errors, peak_held);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
